FILE: sv/sqs_pkg.sv
// -----------------------------------------------------------------------------
// sqs_pkg: shared types and constants of the string queue sorter
// Item layouts, command and status codes, sizes and address helpers.
// -----------------------------------------------------------------------------
package sqs_pkg;

  localparam int ENTRIES = 64;
  localparam int MAX_LEN = 128;

  localparam int SLOT_W = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int LEN_W  = 8;
  localparam int POS_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CS_AW  = $clog2(ENTRIES * MAX_LEN);
  localparam int CS_DEPTH = ENTRIES * MAX_LEN;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SORT   = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_TRUNC     = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NOT_SORTED = 3'd4,
    ST_RSVD5     = 3'd5,
    ST_RSVD6     = 3'd6,
    ST_RSVD7     = 3'd7
  } status_e;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] data_char;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [7:0]       out_char;
    logic             string_end;
    logic             all_done;
    logic [CNT_W-1:0] stored_count;
  } out_t;

  function automatic logic [SLOT_W-1:0] slot_add(logic [SLOT_W-1:0] s,
                                                  logic [CNT_W-1:0] a);
    logic [CNT_W:0] t;
    t = (CNT_W+1)'(s) + (CNT_W+1)'(a);
    if (t >= (CNT_W+1)'(ENTRIES)) t = t - (CNT_W+1)'(ENTRIES);
    return t[SLOT_W-1:0];
  endfunction

  function automatic logic [CS_AW-1:0] cs_addr(logic [SLOT_W-1:0] s,
                                               logic [LEN_W-1:0] p);
    return CS_AW'(s) * CS_AW'(MAX_LEN) + CS_AW'(p[POS_W-1:0]);
  endfunction

endpackage

FILE: sv/string_queue_sorter_core.sv
// -----------------------------------------------------------------------------
// string_queue_sorter_core: queue of byte strings with sort and readout
// Strings are stored per slot in a character RAM; a sort runs an insertion
// sort over an order table, comparing strings character by character.
// -----------------------------------------------------------------------------
// channel  | ports                       | handshake
// command  | start, busy, item_i         | taken when start && !busy
// result   | res_strobe_o, result_o      | one-cycle strobe per item, no stall
//
// Append and remove: the result is registered and follows in the cycle after acceptance.
// Read: order table read, then length and character RAM reads.
// Sort: an order-table fill, then per insertion step an entry load (S_LDV, S_VLEN,
// S_GLV), per predecessor S_PREV, S_PLEN, S_GLP and per character pair S_CI, S_CC.
// Reset clears control state only; RAM contents are undefined until written.
// The receiver cannot stall: each result is shown for exactly one cycle.
// -----------------------------------------------------------------------------
module string_queue_sorter_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  sqs_pkg::in_t  item_i,
  output logic          res_strobe_o,
  output sqs_pkg::out_t result_o
);
  import sqs_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_FILL = 12'b000000000010,
    S_LDV  = 12'b000000000100,
    S_VLEN = 12'b000000001000,
    S_GLV  = 12'b000000010000,
    S_PREV = 12'b000000100000,
    S_PLEN = 12'b000001000000,
    S_GLP  = 12'b000010000000,
    S_CI   = 12'b000100000000,
    S_CC   = 12'b001000000000,
    S_RLEN = 12'b010000000000,
    S_ROUT = 12'b100000000000
  } state_e;

  state_e state_q, state_d;
  logic [SLOT_W-1:0] head_q, head_d, tail_q, tail_d, v_q, v_d, p_q, p_d;
  logic [CNT_W-1:0]  count_q, count_d, rd_ent_q, rd_ent_d, k_q, k_d, j_q, j_d;
  logic [LEN_W-1:0]  rd_pos_q, rd_pos_d, bld_len_q, bld_len_d;
  logic [LEN_W-1:0]  lv_q, lv_d, lp_q, lp_d, pos_q, pos_d;
  logic              sorted_q, sorted_d, mid_q, mid_d, drop_q, drop_d;
  out_t              res_q, res_d;
  logic              strb_q, strb_d;

  logic [SLOT_W-1:0] ord_mem [ENTRIES];
  logic [LEN_W-1:0]  len_mem [ENTRIES];
  logic [SLOT_W-1:0] ord_rdata, ord_raddr, ord_waddr, ord_wdata;
  logic              ord_we;
  logic [LEN_W-1:0]  len_rdata, len_wdata;
  logic [SLOT_W-1:0] len_waddr;
  logic              len_we;
  logic              cs_we;
  logic [CS_AW-1:0]  cs_waddr, cs_raddr_a;
  logic [7:0]        cs_rdata_a, cs_rdata_b;

  logic              accept, drop_n, greater, decide;
  logic [LEN_W-1:0]  cur_len, min_len;

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);
  assign min_len = (lp_q < lv_q) ? lp_q : lv_q;

  always_ff @(posedge clk_i) begin
    if (ord_we) ord_mem[ord_waddr] <= ord_wdata;
    ord_rdata <= ord_mem[ord_raddr];
    if (len_we) len_mem[len_waddr] <= len_wdata;
    len_rdata <= len_mem[ord_rdata];
  end

  sqs_char_ram u_char_ram (
    .clk_i     (clk_i),
    .we_i      (cs_we),
    .waddr_i   (cs_waddr),
    .wdata_i   (item_i.data_char),
    .raddr_a_i (cs_raddr_a),
    .raddr_b_i (cs_addr(v_q, pos_q)),
    .rdata_a_o (cs_rdata_a),
    .rdata_b_o (cs_rdata_b)
  );

  assign cs_raddr_a = (state_q == S_RLEN) ? cs_addr(ord_rdata, rd_pos_q)
                                          : cs_addr(p_q, pos_q);

  always_comb begin
    state_d = state_q; head_d = head_q; tail_d = tail_q; count_d = count_q;
    rd_ent_d = rd_ent_q; rd_pos_d = rd_pos_q; bld_len_d = bld_len_q;
    k_d = k_q; j_d = j_q; v_d = v_q; p_d = p_q; lv_d = lv_q; lp_d = lp_q;
    pos_d = pos_q; sorted_d = sorted_q; mid_d = mid_q; drop_d = drop_q;
    strb_d = 1'b0;
    res_d = res_q;
    ord_we = 1'b0; ord_waddr = j_q[SLOT_W-1:0]; ord_wdata = v_q;
    ord_raddr = rd_ent_q[SLOT_W-1:0];
    len_we = 1'b0; len_waddr = tail_q; len_wdata = '0;
    cs_we = 1'b0; cs_waddr = cs_addr(tail_q, bld_len_q);
    drop_n = drop_q; cur_len = bld_len_q;
    greater = 1'b0; decide = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          strb_d = 1'b1;
          res_d = '0;
          case (item_i.command)
            CMD_APPEND: begin
              sorted_d = 1'b0; rd_ent_d = '0; rd_pos_d = '0;
              drop_n  = mid_q ? drop_q : (count_q >= CNT_W'(ENTRIES));
              cur_len = mid_q ? bld_len_q : '0;
              bld_len_d = cur_len;
              if (drop_n) begin
                res_d.status = ST_FULL;
              end else if (cur_len < LEN_W'(MAX_LEN)) begin
                cs_we = 1'b1;
                cs_waddr = cs_addr(tail_q, cur_len);
                len_we = 1'b1;
                len_wdata = cur_len + 1'b1;
                bld_len_d = cur_len + 1'b1;
              end else begin
                res_d.status = ST_TRUNC;
              end
              if (item_i.last_char) begin
                if (!drop_n) begin
                  tail_d = slot_add(tail_q, CNT_W'(1));
                  count_d = count_q + 1'b1;
                end
                mid_d = 1'b0; drop_d = 1'b0;
              end else begin
                mid_d = 1'b1; drop_d = drop_n;
              end
            end
            CMD_REMOVE: begin
              sorted_d = 1'b0; rd_ent_d = '0; rd_pos_d = '0;
              if (count_q == '0) begin
                res_d.status = ST_EMPTY;
              end else begin
                head_d = slot_add(head_q, CNT_W'(1));
                count_d = count_q - 1'b1;
              end
            end
            CMD_SORT: begin
              mid_d = 1'b0; drop_d = 1'b0; sorted_d = 1'b1;
              rd_ent_d = '0; rd_pos_d = '0; k_d = '0;
              if (count_q != '0) begin
                strb_d = 1'b0;
                state_d = S_FILL;
              end
            end
            default: begin
              if (!sorted_q) begin
                res_d.status = ST_NOT_SORTED;
              end else if (rd_ent_q >= count_q) begin
                res_d.all_done = 1'b1;
                count_d = '0; head_d = '0; tail_d = '0; sorted_d = 1'b0;
                rd_ent_d = '0; rd_pos_d = '0; mid_d = 1'b0; drop_d = 1'b0;
              end else begin
                strb_d = 1'b0;
                state_d = S_RLEN;
              end
            end
          endcase
          res_d.stored_count = count_d;
        end
      end
      S_FILL: begin
        ord_we = 1'b1;
        ord_waddr = k_q[SLOT_W-1:0];
        ord_wdata = slot_add(head_q, k_q);
        if (k_q + 1'b1 >= count_q) begin
          k_d = CNT_W'(1);
          if (count_q == CNT_W'(1)) begin
            strb_d = 1'b1; state_d = S_IDLE;
          end else begin
            state_d = S_LDV;
          end
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_LDV: begin
        ord_raddr = k_q[SLOT_W-1:0];
        state_d = S_VLEN;
      end
      S_VLEN: begin
        v_d = ord_rdata;
        state_d = S_GLV;
      end
      S_GLV: begin
        lv_d = len_rdata;
        j_d = k_q;
        state_d = S_PREV;
      end
      S_PREV: begin
        if (j_q == '0) begin
          decide = 1'b1;
        end else begin
          ord_raddr = j_q[SLOT_W-1:0] - 1'b1;
          state_d = S_PLEN;
        end
      end
      S_PLEN: begin
        p_d = ord_rdata;
        state_d = S_GLP;
      end
      S_GLP: begin
        lp_d = len_rdata;
        pos_d = '0;
        state_d = S_CI;
      end
      S_CI: begin
        if (pos_q == min_len) begin
          decide = 1'b1;
          greater = lp_q > lv_q;
        end else begin
          state_d = S_CC;
        end
      end
      S_CC: begin
        if (cs_rdata_a != cs_rdata_b) begin
          decide = 1'b1;
          greater = cs_rdata_a > cs_rdata_b;
        end else begin
          pos_d = pos_q + 1'b1;
          state_d = S_CI;
        end
      end
      S_RLEN: begin
        state_d = S_ROUT;
      end
      S_ROUT: begin
        res_d = '0;
        strb_d = 1'b1;
        state_d = S_IDLE;
        res_d.out_char = (rd_pos_q < len_rdata) ? cs_rdata_a : 8'd0;
        if (LEN_W'(rd_pos_q + 1'b1) >= len_rdata) begin
          res_d.string_end = 1'b1;
          rd_ent_d = rd_ent_q + 1'b1;
          rd_pos_d = '0;
        end else begin
          rd_pos_d = rd_pos_q + 1'b1;
        end
        res_d.stored_count = count_q;
      end
      default: state_d = S_IDLE;
    endcase

    if (decide) begin
      ord_we = 1'b1;
      ord_waddr = j_q[SLOT_W-1:0];
      if (greater) begin
        ord_wdata = p_q;
        j_d = j_q - 1'b1;
        state_d = S_PREV;
      end else begin
        ord_wdata = v_q;
        k_d = k_q + 1'b1;
        if (k_q + 1'b1 >= count_q) begin
          strb_d = 1'b1; state_d = S_IDLE;
        end else begin
          state_d = S_LDV;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; head_q <= '0; tail_q <= '0; count_q <= '0;
      rd_ent_q <= '0; rd_pos_q <= '0; bld_len_q <= '0; k_q <= '0; j_q <= '0;
      sorted_q <= 1'b0; mid_q <= 1'b0; drop_q <= 1'b0; strb_q <= 1'b0;
    end else begin
      state_q <= state_d; head_q <= head_d; tail_q <= tail_d;
      count_q <= count_d; rd_ent_q <= rd_ent_d; rd_pos_q <= rd_pos_d;
      bld_len_q <= bld_len_d; k_q <= k_d; j_q <= j_d; sorted_q <= sorted_d;
      mid_q <= mid_d; drop_q <= drop_d; strb_q <= strb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d; p_q <= p_d; lv_q <= lv_d; lp_q <= lp_d; pos_q <= pos_d;
    res_q <= res_d;
  end

  assign res_strobe_o = strb_q;
  assign result_o = res_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(ENTRIES)) else $error("count out of range");
  a_append_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (item_i.command == CMD_APPEND) |=> res_strobe_o)
    else $error("append without result");
  a_sort_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CI) |-> (pos_q <= min_len)) else $error("compare overrun");

endmodule

FILE: sv/sqs_char_ram.sv
// -----------------------------------------------------------------------------
// sqs_char_ram: character store
// One write port, two registered read ports.
// -----------------------------------------------------------------------------
module sqs_char_ram (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [sqs_pkg::CS_AW-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic [sqs_pkg::CS_AW-1:0] raddr_a_i,
  input  logic [sqs_pkg::CS_AW-1:0] raddr_b_i,
  output logic [7:0]               rdata_a_o,
  output logic [7:0]               rdata_b_o
);
  import sqs_pkg::*;

  logic [7:0] mem [CS_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule
